/* hw/rtl/sbdc_pkg.sv */
// Shared types and constants of the sector buffered disk controller.
package sbdc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned SIZE_W     = 4;
    localparam int unsigned SECTOR_W   = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;

    // Access kinds carried with each request beat.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Only single-byte accesses are honoured.
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 4'd1;

    // Values written to the command register.
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;

    // Value returned for unreadable registers and wide accesses.
    localparam logic [BYTE_W-1:0] RD_INVALID = 8'hff;

    // Reset values of the configuration registers.
    localparam logic                  MEDIA_PRESENT_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] MEDIA_SECTORS_RST = 7'd64;

    typedef enum logic [ADDR_W-1:0] {
        RA_COMMAND = 3'd0,
        RA_STATUS  = 3'd1,
        RA_SEC_LO  = 3'd2,
        RA_SEC_HI  = 3'd3,
        RA_DATA    = 3'd4,
        RA_ERROR   = 3'd5
    } reg_addr_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_READY = 2'd2,
        ST_ERROR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ER_NONE     = 3'd0,
        ER_NO_MEDIA = 3'd1,
        ER_RANGE    = 3'd2,
        ER_IO       = 3'd3,
        ER_SHORT    = 3'd4
    } error_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEDIA_PRESENT = 1'b0,
        CFG_MEDIA_SECTORS = 1'b1
    } cfg_idx_t;

endpackage

/* hw/rtl/sbdc_ram.sv */
// Byte-wide simple dual-port memory with one write port and a registered read port.
module sbdc_ram #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [sbdc_pkg::BYTE_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [sbdc_pkg::BYTE_W-1:0] rdata
);

    logic [sbdc_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/sector_buffered_disk_controller.sv */
// Top level of the sector buffered disk controller: register file, command sequencer and memories.
//
//   Channel  Direction  Signals                          Contents
//   s_       in         s_tvalid s_tready s_tdata s_tuser one register access per beat
//   m_       out        m_tvalid m_tready m_tdata        one result byte per access beat
//   cfg_     in         cfg_valid cfg_ready cfg_index    media configuration writes
//                       cfg_data
//
// Results: an access has its result in the output register from the edge that takes its beat;
// a data read first passes the sector buffer's registered read port before the output register.
// Stalls: commands 1 and 2 that start a copy hold off the request channel until its write-back ends
// while one byte a cycle moves between medium and buffer; a full output register also holds it off.
// Reset: both memories are swept to zero, one byte a cycle, over all MEDIA_SECTOR_COUNT *
// SECTOR_BYTES medium bytes (32768 by default); only configuration writes are taken meanwhile.
module sector_buffered_disk_controller #(
    parameter int unsigned SECTOR_BYTES       = 512,
    parameter int unsigned MEDIA_SECTOR_COUNT = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [3:0] access_size, [11:4] wdata, [15:12] zero
    input  logic [3:0]                         s_tuser,   // [0] func, [3:1] reg_addr
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sbdc_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] rdata
    // Configuration channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Buffer and medium geometry.
    localparam int unsigned BUF_AW    = $clog2(SECTOR_BYTES);
    localparam int unsigned PTR_W     = $clog2(SECTOR_BYTES + 1);
    localparam int unsigned MED_DEPTH = MEDIA_SECTOR_COUNT * SECTOR_BYTES;
    localparam int unsigned MED_AW    = $clog2(MED_DEPTH);
    localparam int unsigned SEC_W     = (MEDIA_SECTOR_COUNT > 1) ?
                                        $clog2(MEDIA_SECTOR_COUNT) : 1;
    localparam int unsigned LIM_W     = sbdc_pkg::SECTOR_W + 1;

    localparam logic [PTR_W-1:0]  PTR_FULL = PTR_W'(SECTOR_BYTES);
    localparam logic [BUF_AW-1:0] BUF_LAST = BUF_AW'(SECTOR_BYTES - 1);
    localparam logic [MED_AW-1:0] MED_LAST = MED_AW'(MED_DEPTH - 1);
    localparam logic [LIM_W-1:0]  SEC_MAX  = LIM_W'(MEDIA_SECTOR_COUNT);

    // Sequencer states: the clearing sweep, waiting for requests, loading the buffer byte of
    // a data read, the byte copy and the final write-back of the copy pipeline.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DREAD,
        S_COPY,
        S_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [sbdc_pkg::SECTOR_W-1:0]   sector_reg, sector_next;
    logic [PTR_W-1:0]                ptr_reg, ptr_next;
    sbdc_pkg::status_t               status_reg, status_next;
    sbdc_pkg::error_t                error_reg, error_next;
    logic                            present_reg, present_next;
    logic [sbdc_pkg::CFG_DATA_W-1:0] msec_reg, msec_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sbdc_pkg::BYTE_W-1:0]     out_data_reg, out_data_next;
    logic [MED_AW-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [BUF_AW-1:0]               clr_buf_reg, clr_buf_next;
    logic                            dir_reg, dir_next;          // 1: buffer to medium
    logic [BUF_AW-1:0]               cnt_reg, cnt_next;
    logic [MED_AW-1:0]               med_addr_reg, med_addr_next;
    logic                            wr_pend_reg, wr_pend_next;
    logic [BUF_AW-1:0]               wr_idx_reg, wr_idx_next;
    logic [MED_AW-1:0]               wr_maddr_reg, wr_maddr_next;

    // Memory ports.
    logic                        buf_we;
    logic [BUF_AW-1:0]           buf_waddr, buf_raddr;
    logic [sbdc_pkg::BYTE_W-1:0] buf_wdata, buf_rdata;
    logic                        med_we;
    logic [MED_AW-1:0]           med_waddr;
    logic [sbdc_pkg::BYTE_W-1:0] med_wdata, med_rdata;

    // Request fields.
    logic                              in_func;
    sbdc_pkg::reg_addr_t               in_addr;
    logic [sbdc_pkg::SIZE_W-1:0]       in_size;
    logic [sbdc_pkg::BYTE_W-1:0]       in_wdata;
    logic                              in_accept;

    // Command checks and address helpers.
    logic [LIM_W-1:0]  sec_limit;
    logic              out_of_range;
    logic [PTR_W-1:0]  ptr_eff;
    logic [MED_AW-1:0] med_base;

    assign in_func  = s_tuser[0];
    assign in_addr  = sbdc_pkg::reg_addr_t'(s_tuser[3:1]);
    assign in_size  = s_tdata[3:0];
    assign in_wdata = s_tdata[11:4];

    // A request is taken only while the sequencer waits and the result slot is free
    // or being emptied in the same cycle.
    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // The configured sector count saturates at the size of the medium.
    assign sec_limit    = (LIM_W'(msec_reg) > SEC_MAX) ? SEC_MAX : LIM_W'(msec_reg);
    assign out_of_range = LIM_W'(sector_reg) >= sec_limit;

    // A data read at or beyond the end of the buffer wraps to its first byte.
    assign ptr_eff  = (ptr_reg >= PTR_FULL) ? '0 : ptr_reg;
    assign med_base = MED_AW'(MED_AW'(sector_reg[SEC_W-1:0]) * MED_AW'(SECTOR_BYTES));

    always_comb
    begin
        state_next     = state_reg;
        sector_next    = sector_reg;
        ptr_next       = ptr_reg;
        status_next    = status_reg;
        error_next     = error_reg;
        present_next   = present_reg;
        msec_next      = msec_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_buf_next   = clr_buf_reg;
        dir_next       = dir_reg;
        cnt_next       = cnt_reg;
        med_addr_next  = med_addr_reg;
        wr_pend_next   = 1'b0;
        wr_idx_next    = wr_idx_reg;
        wr_maddr_next  = wr_maddr_reg;

        buf_we    = 1'b0;
        buf_waddr = wr_idx_reg;
        buf_wdata = med_rdata;
        buf_raddr = cnt_reg;
        med_we    = 1'b0;
        med_waddr = wr_maddr_reg;
        med_wdata = buf_rdata;

        // The result slot empties when the consumer takes the beat.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                buf_we    = 1'b1;
                buf_waddr = clr_buf_reg;
                buf_wdata = '0;
                med_we    = 1'b1;
                med_waddr = clr_cnt_reg;
                med_wdata = '0;
                clr_buf_next = (clr_buf_reg == BUF_LAST) ? '0 : clr_buf_reg + 1'b1;
                if (clr_cnt_reg == MED_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (in_func == sbdc_pkg::FUNC_READ) ?
                                     sbdc_pkg::RD_INVALID : '0;
                    if (in_size == sbdc_pkg::SIZE_BYTE)
                    begin
                        if (in_func == sbdc_pkg::FUNC_READ)
                        begin
                            unique case (in_addr)
                                sbdc_pkg::RA_STATUS:
                                    out_data_next = sbdc_pkg::BYTE_W'(status_reg);
                                sbdc_pkg::RA_SEC_LO:
                                    out_data_next = sector_reg[7:0];
                                sbdc_pkg::RA_SEC_HI:
                                    out_data_next = sector_reg[15:8];
                                sbdc_pkg::RA_ERROR:
                                    out_data_next = sbdc_pkg::BYTE_W'(error_reg);
                                sbdc_pkg::RA_DATA:
                                begin
                                    // The byte arrives from the buffer next cycle.
                                    out_valid_next = 1'b0;
                                    buf_raddr      = ptr_eff[BUF_AW-1:0];
                                    ptr_next       = ptr_eff + 1'b1;
                                    state_next     = S_DREAD;
                                end
                                default:
                                    out_data_next = sbdc_pkg::RD_INVALID;
                            endcase
                        end
                        else
                        begin
                            unique case (in_addr)
                                sbdc_pkg::RA_COMMAND:
                                begin
                                    if (in_wdata == sbdc_pkg::CMD_READ ||
                                        in_wdata == sbdc_pkg::CMD_WRITE)
                                    begin
                                        if (in_wdata == sbdc_pkg::CMD_WRITE &&
                                            ptr_reg != PTR_FULL)
                                        begin
                                            status_next = sbdc_pkg::ST_ERROR;
                                            error_next  = sbdc_pkg::ER_SHORT;
                                        end
                                        else if (!present_reg)
                                        begin
                                            status_next = sbdc_pkg::ST_ERROR;
                                            error_next  = sbdc_pkg::ER_NO_MEDIA;
                                        end
                                        else if (out_of_range)
                                        begin
                                            status_next = sbdc_pkg::ST_ERROR;
                                            error_next  = sbdc_pkg::ER_RANGE;
                                        end
                                        else
                                        begin
                                            // Nothing is accepted until the copy ends, so
                                            // the final status can be set now.
                                            status_next   = sbdc_pkg::ST_READY;
                                            error_next    = sbdc_pkg::ER_NONE;
                                            dir_next      = (in_wdata == sbdc_pkg::CMD_WRITE);
                                            cnt_next      = '0;
                                            med_addr_next = med_base;
                                            state_next    = S_COPY;
                                            if (in_wdata == sbdc_pkg::CMD_READ)
                                            begin
                                                ptr_next = '0;
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        status_next = sbdc_pkg::ST_ERROR;
                                        error_next  = sbdc_pkg::ER_IO;
                                    end
                                end
                                sbdc_pkg::RA_SEC_LO, sbdc_pkg::RA_SEC_HI:
                                begin
                                    if (in_addr == sbdc_pkg::RA_SEC_LO)
                                    begin
                                        sector_next[7:0] = in_wdata;
                                    end
                                    else
                                    begin
                                        sector_next[15:8] = in_wdata;
                                    end
                                    ptr_next    = '0;
                                    status_next = sbdc_pkg::ST_IDLE;
                                    error_next  = sbdc_pkg::ER_NONE;
                                end
                                sbdc_pkg::RA_DATA:
                                begin
                                    // Writes to a full buffer are dropped.
                                    if (ptr_reg < PTR_FULL)
                                    begin
                                        buf_we    = 1'b1;
                                        buf_waddr = ptr_reg[BUF_AW-1:0];
                                        buf_wdata = in_wdata;
                                        ptr_next  = ptr_reg + 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
            end

            S_DREAD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = buf_rdata;
                state_next     = S_IDLE;
            end

            S_COPY:
            begin
                // Read one source byte and queue its write for the next cycle.
                buf_raddr     = cnt_reg;
                wr_pend_next  = 1'b1;
                wr_idx_next   = cnt_reg;
                wr_maddr_next = med_addr_reg;
                med_addr_next = med_addr_reg + 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == BUF_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write-back stage of the copy pipeline.
        if (wr_pend_reg)
        begin
            if (dir_reg)
            begin
                med_we    = 1'b1;
                med_waddr = wr_maddr_reg;
                med_wdata = buf_rdata;
            end
            else
            begin
                buf_we    = 1'b1;
                buf_waddr = wr_idx_reg;
                buf_wdata = med_rdata;
            end
        end

        // Configuration writes.
        if (cfg_valid)
        begin
            if (cfg_index == sbdc_pkg::CFG_MEDIA_PRESENT)
            begin
                present_next = cfg_data[0];
            end
            else
            begin
                msec_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sector_reg    <= '0;
            ptr_reg       <= '0;
            status_reg    <= sbdc_pkg::ST_IDLE;
            error_reg     <= sbdc_pkg::ER_NONE;
            present_reg   <= sbdc_pkg::MEDIA_PRESENT_RST;
            msec_reg      <= sbdc_pkg::MEDIA_SECTORS_RST;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            clr_cnt_reg   <= '0;
            clr_buf_reg   <= '0;
            dir_reg       <= 1'b0;
            cnt_reg       <= '0;
            med_addr_reg  <= '0;
            wr_pend_reg   <= 1'b0;
            wr_idx_reg    <= '0;
            wr_maddr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sector_reg    <= sector_next;
            ptr_reg       <= ptr_next;
            status_reg    <= status_next;
            error_reg     <= error_next;
            present_reg   <= present_next;
            msec_reg      <= msec_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_buf_reg   <= clr_buf_next;
            dir_reg       <= dir_next;
            cnt_reg       <= cnt_next;
            med_addr_reg  <= med_addr_next;
            wr_pend_reg   <= wr_pend_next;
            wr_idx_reg    <= wr_idx_next;
            wr_maddr_reg  <= wr_maddr_next;
        end
    end

    // One-sector data buffer.
    sbdc_ram #(
        .DEPTH (SECTOR_BYTES),
        .AW    (BUF_AW)
    ) u_buffer (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // Medium store; its read port follows the copy engine's address.
    sbdc_ram #(
        .DEPTH (MED_DEPTH),
        .AW    (MED_AW)
    ) u_medium (
        .clk   (clk),
        .we    (med_we),
        .waddr (med_waddr),
        .wdata (med_wdata),
        .raddr (med_addr_reg),
        .rdata (med_rdata)
    );

endmodule
